[src/u8s_pkg.sv]
// Shared types and constants of the UTF-8 stream sanitizer.
package u8s_pkg;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_UNITS = 4;
    localparam int CNT_W     = 3;

    localparam logic [7:0] ASCII_LIM  = 8'h80;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_LIM   = 8'hF5;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] E0_MIN     = 8'hA0;
    localparam logic [7:0] ED_LIM     = 8'hA0;
    localparam logic [7:0] F0_MIN     = 8'h90;
    localparam logic [7:0] F4_MAX     = 8'h8F;

    localparam logic [7:0] REPL_SEQ [3] = '{8'hEF, 8'hBF, 8'hBD};

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic       repl;
        logic [7:0] data;
    } t_unit;

    typedef struct packed {
        logic [CNT_W-1:0]            cnt;
        t_unit [CMD_UNITS-1:0]       units;
    } t_cmd;

endpackage

[src/u8s_front.sv]
// Front end: holds the pending sequence and turns each request into an emit command.
module u8s_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  u8s_pkg::t_in  i_data,
    output u8s_pkg::t_cmd o_cmd
);
    import u8s_pkg::*;

    logic [7:0] r_lead, n_lead;
    logic [1:0] r_hc, n_hc;
    logic [2:0] r_seq, n_seq;
    logic [7:0] r_cont [2];
    logic [7:0] n_cont [2];

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic res;
        res = 1'b1;
        if (lead == LEAD_E0) res = (b >= E0_MIN);
        if (lead == LEAD_ED) res = (b < ED_LIM);
        if (lead == LEAD_F0) res = (b >= F0_MIN);
        if (lead == LEAD_F4) res = (b <= F4_MAX);
        return res;
    endfunction

    always_comb begin
        t_cmd             c;
        logic [CNT_W-1:0] n;
        logic             take_fresh;
        logic             ok;
        logic [7:0]       b;
        c          = '0;
        n          = '0;
        take_fresh = 1'b1;
        ok         = 1'b0;
        b          = i_data.in_byte;
        n_lead     = r_lead;
        n_hc       = r_hc;
        n_seq      = r_seq;
        n_cont     = r_cont;
        if (r_seq != 3'd0) begin
            ok = ((b & CONT_MASK) == CONT_TAG);
            if (ok && r_hc == 2'd0) begin
                ok = second_ok(r_lead, b);
            end
            if (ok) begin
                take_fresh = 1'b0;
                if (({1'b0, r_hc} + 3'd2 >= r_seq) || r_hc >= 2'd2) begin
                    c.units[n[1:0]] = '{repl: 1'b0, data: r_lead};
                    n = n + 3'd1;
                    for (int k = 0; k < 2; k++) begin
                        if (2'(k) < r_hc) begin
                            c.units[n[1:0]] = '{repl: 1'b0, data: r_cont[k]};
                            n = n + 3'd1;
                        end
                    end
                    c.units[n[1:0]] = '{repl: 1'b0, data: b};
                    n = n + 3'd1;
                    n_lead = '0;
                    n_hc   = '0;
                    n_seq  = '0;
                end else begin
                    n_cont[r_hc[0]] = b;
                    n_hc = r_hc + 2'd1;
                end
            end else begin
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) <= r_hc) begin
                        c.units[n[1:0]] = '{repl: 1'b1, data: 8'h00};
                        n = n + 3'd1;
                    end
                end
                n_lead = '0;
                n_hc   = '0;
                n_seq  = '0;
            end
        end
        if (take_fresh) begin
            if (b < ASCII_LIM) begin
                c.units[n[1:0]] = '{repl: 1'b0, data: b};
                n = n + 3'd1;
            end else if (b < LEAD2_MIN || b >= LEAD_LIM) begin
                c.units[n[1:0]] = '{repl: 1'b1, data: 8'h00};
                n = n + 3'd1;
            end else begin
                n_lead = b;
                n_hc   = '0;
                if (b < LEAD3_MIN) begin
                    n_seq = 3'd2;
                end else if (b < LEAD4_MIN) begin
                    n_seq = 3'd3;
                end else begin
                    n_seq = 3'd4;
                end
            end
        end
        if (i_data.in_end && n_seq != 3'd0) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) <= n_hc) begin
                    c.units[n[1:0]] = '{repl: 1'b1, data: 8'h00};
                    n = n + 3'd1;
                end
            end
            n_lead = '0;
            n_hc   = '0;
            n_seq  = '0;
        end
        c.cnt = n;
        o_cmd = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_hc   <= '0;
            r_seq  <= '0;
        end else if (i_accept) begin
            r_lead <= n_lead;
            r_hc   <= n_hc;
            r_seq  <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cont <= n_cont;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_data.in_end) |=> (r_seq == 3'd0))
        else $error("sequence still pending after end of stream");
    a_hc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != 3'd0) |-> ({1'b0, r_hc} + 3'd1 < r_seq))
        else $error("held count reaches sequence length");
`endif

endmodule

[src/u8s_cmd_fifo.sv]
// Command queue between the front end and the output expander.
module u8s_cmd_fifo #(
    parameter int DEPTH = u8s_pkg::CMD_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u8s_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output u8s_pkg::t_cmd o_head
);
    import u8s_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");
    a_no_empty_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_cmd.cnt != '0))
        else $error("empty command queued");
`endif

endmodule

[src/u8s_back.sv]
// Back end: expands queued commands into output bytes through an output register.
module u8s_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  u8s_pkg::t_cmd i_head,
    output logic          o_head_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output u8s_pkg::t_out o_data
);
    import u8s_pkg::*;

    logic [1:0] r_unit, n_unit;
    logic [1:0] r_sub, n_sub;
    logic       r_valid, n_valid;
    t_out       r_out;
    t_unit      cur;
    logic [7:0] cur_byte;
    logic       unit_done;
    logic       last;
    logic       advance;

    assign cur       = i_head.units[r_unit];
    assign cur_byte  = cur.repl ? REPL_SEQ[r_sub] : cur.data;
    assign unit_done = !cur.repl || (r_sub == 2'd2);
    assign last      = unit_done && (({1'b0, r_unit} + 3'd1) == i_head.cnt);
    assign advance   = i_head_valid && (!r_valid || i_pop);
    assign o_head_pop = advance && last;
    assign o_empty   = !r_valid;
    assign o_data    = r_out;

    always_comb begin
        n_unit  = r_unit;
        n_sub   = r_sub;
        n_valid = r_valid;
        if (advance) begin
            n_valid = 1'b1;
            if (unit_done) begin
                n_sub  = '0;
                n_unit = last ? 2'd0 : r_unit + 2'd1;
            end else begin
                n_sub = r_sub + 2'd1;
            end
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit  <= '0;
            r_sub   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_unit  <= n_unit;
            r_sub   <= n_sub;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= '{out_byte: cur_byte, run_last: last};
        end
    end

`ifndef SYNTHESIS
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub != 2'd3)
        else $error("replacement index out of range");
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ({1'b0, r_unit} < i_head.cnt))
        else $error("unit index beyond command");
`endif

endmodule

[src/utf8_stream_sanitizer.sv]
// Top level of the UTF-8 stream sanitizer.
//
//  channel | handshake         | payload
//  --------+-------------------+-------------------------------
//  input   | i_push / o_full   | i_data  (in_byte, in_end)
//  output  | i_pop  / o_empty  | o_data  (out_byte, run_last)
//
// One input byte is taken per cycle while the command queue has room.
// Output leaves at one byte per cycle while i_pop is high; an input byte yields 0
// to 12 bytes, so expansion (replacements, three bytes each) fills the queue and
// raises o_full. A request's first byte passes the queue, then the output register.
// Synchronous reset clears the pending sequence, queue and output valid flag.
// A stalled output holds its byte; the front keeps accepting until the queue fills.
module utf8_stream_sanitizer #(
    parameter int CMD_DEPTH = u8s_pkg::CMD_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u8s_pkg::t_in  i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output u8s_pkg::t_out o_data
);
    import u8s_pkg::*;

    logic accept;
    t_cmd cmd;
    t_cmd head;
    logic head_valid;
    logic head_pop;

    assign accept = i_push && !o_full;

    u8s_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .o_cmd    (cmd)
    );

    u8s_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && (cmd.cnt != '0)),
        .i_cmd   (cmd),
        .i_pop   (head_pop),
        .o_full  (o_full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    u8s_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_data       (o_data)
    );

endmodule

[tb/utf8_stream_sanitizer_tb.sv]
// Self-checking testbench for the UTF-8 stream sanitizer: directed and random byte streams.
`timescale 1ns / 100ps

module utf8_stream_sanitizer_tb;

    import u8s_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 120;
    localparam int CALM_TAIL = 40;
    localparam int DRAIN_CYCLES = 16;

    class sanitize_tracker;
        t_out       pending_bytes[$];
        logic [7:0] burst_q[$];
        int         errors;
        logic [7:0] lead_byte;
        logic [7:0] cont_bytes[3];
        logic [1:0] held_cnt;
        logic [2:0] seq_len;

        function new();
            errors   = 0;
            lead_byte = '0;
            held_cnt = '0;
            seq_len  = '0;
        endfunction

        function int waiting();
            return pending_bytes.size();
        endfunction

        function void queue_byte(logic [7:0] v);
            burst_q = {burst_q, v};
        endfunction

        function void add_repl();
            for (int i = 0; i < 3; i++) begin
                queue_byte(REPL_SEQ[i]);
            end
        endfunction

        function void flush_partial();
            if (seq_len != 0) begin
                add_repl();
                for (int k = 0; k < held_cnt; k++) begin
                    add_repl();
                end
                lead_byte = '0;
                held_cnt  = '0;
                seq_len   = '0;
            end
        endfunction

        function void note_request(t_in req);
            logic [7:0] b;
            bit         ok;
            bit         fresh;
            t_out       exp_byte;
            b     = req.in_byte;
            fresh = 1'b1;
            burst_q.delete();
            if (seq_len != 0) begin
                ok = (b & CONT_MASK) == CONT_TAG;
                if (ok && held_cnt == 0) begin
                    case (lead_byte)
                        LEAD_E0: ok = b >= E0_MIN;
                        LEAD_ED: ok = b < ED_LIM;
                        LEAD_F0: ok = b >= F0_MIN;
                        LEAD_F4: ok = b <= F4_MAX;
                        default: ok = 1'b1;
                    endcase
                end
                if (ok) begin
                    fresh = 1'b0;
                    if (held_cnt + 2 >= seq_len || held_cnt >= 2) begin
                        queue_byte(lead_byte);
                        for (int k = 0; k < held_cnt; k++) begin
                            queue_byte(cont_bytes[k]);
                        end
                        queue_byte(b);
                        lead_byte = '0;
                        held_cnt  = '0;
                        seq_len   = '0;
                    end else begin
                        cont_bytes[held_cnt] = b;
                        held_cnt = held_cnt + 1'b1;
                    end
                end else begin
                    flush_partial();
                end
            end
            if (fresh) begin
                if (b < ASCII_LIM) begin
                    queue_byte(b);
                end else if (b < LEAD2_MIN || b >= LEAD_LIM) begin
                    add_repl();
                end else begin
                    lead_byte = b;
                    held_cnt  = '0;
                    if (b < LEAD3_MIN) begin
                        seq_len = 3'd2;
                    end else if (b < LEAD4_MIN) begin
                        seq_len = 3'd3;
                    end else begin
                        seq_len = 3'd4;
                    end
                end
            end
            if (req.in_end) begin
                flush_partial();
            end
            foreach (burst_q[i]) begin
                exp_byte.out_byte = burst_q[i];
                exp_byte.run_last = (i == burst_q.size() - 1);
                pending_bytes = {pending_bytes, exp_byte};
            end
        endfunction

        function void check_byte(t_out got);
            t_out exp_byte;
            if (pending_bytes.size() == 0) begin
                $display("%0t: result byte expected none actual %02h run_last %0b",
                         $time, got.out_byte, got.run_last);
                errors++;
            end else begin
                exp_byte = pending_bytes.pop_front();
                if (got.out_byte !== exp_byte.out_byte) begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, exp_byte.out_byte, got.out_byte);
                    errors++;
                end
                if (got.run_last !== exp_byte.run_last) begin
                    $display("%0t: run_last expected %0b actual %0b",
                             $time, exp_byte.run_last, got.run_last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_push;
    t_in   i_data;
    logic  o_full;
    logic  i_pop;
    logic  o_empty;
    t_out  o_data;

    sanitize_tracker tracker;
    t_in             stim_q[$];
    bit              idle_on;
    int              pop_hold;

    utf8_stream_sanitizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (i_data),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full) begin
            tracker.note_request(i_data);
        end
        if (i_rst_n && i_pop && !o_empty) begin
            tracker.check_byte(o_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop_hold = pop_hold - 1;
            i_pop <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            pop_hold = $urandom_range(19, 1) - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    function automatic void add_stim(logic [7:0] b, logic fin);
        t_in req;
        req.in_byte = b;
        req.in_end  = fin;
        stim_q = {stim_q, req};
    endfunction

    function automatic logic [7:0] cont_in(int lo, int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic void add_sequence(bit broken);
        logic [7:0] seq[$];
        logic [7:0] lead;
        int         len;
        int         cut;
        len = $urandom_range(4, 1);
        case (len)
            1: seq = {seq, cont_in(8'h00, 8'h7F)};
            2: begin
                seq = {seq, cont_in(8'hC2, 8'hDF)};
                seq = {seq, cont_in(8'h80, 8'hBF)};
            end
            3: begin
                lead = cont_in(8'hE0, 8'hEF);
                seq = {seq, lead};
                if (lead == LEAD_E0) begin
                    seq = {seq, cont_in(8'hA0, 8'hBF)};
                end else if (lead == LEAD_ED) begin
                    seq = {seq, cont_in(8'h80, 8'h9F)};
                end else begin
                    seq = {seq, cont_in(8'h80, 8'hBF)};
                end
                seq = {seq, cont_in(8'h80, 8'hBF)};
            end
            default: begin
                lead = cont_in(8'hF0, 8'hF4);
                seq = {seq, lead};
                if (lead == LEAD_F0) begin
                    seq = {seq, cont_in(8'h90, 8'hBF)};
                end else if (lead == LEAD_F4) begin
                    seq = {seq, cont_in(8'h80, 8'h8F)};
                end else begin
                    seq = {seq, cont_in(8'h80, 8'hBF)};
                end
                seq = {seq, cont_in(8'h80, 8'hBF)};
                seq = {seq, cont_in(8'h80, 8'hBF)};
            end
        endcase
        cut = (broken && len > 1) ? $urandom_range(len - 1, 1) : 0;
        for (int i = 0; i < len - cut; i++) begin
            add_stim(seq[i], $urandom_range(0, 19) == 0);
        end
    endfunction

    task automatic send_request(t_in req);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (tracker.waiting() != 0) @(posedge i_clk);
    endtask

    initial begin
        int pick;
        tracker  = new();
        idle_on  = 1'b1;
        pop_hold = 0;
        i_rst_n <= 1'b0;
        i_push  <= 1'b0;
        i_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_stim(8'h00, 1'b0);
        add_stim(8'h7F, 1'b0);
        add_stim(8'h80, 1'b0);
        add_stim(8'hC0, 1'b0);
        add_stim(8'hC1, 1'b0);
        add_stim(8'hF5, 1'b0);
        add_stim(8'hFF, 1'b1);
        add_stim(8'hC2, 1'b0);
        add_stim(8'h80, 1'b0);
        add_stim(8'hE0, 1'b0);
        add_stim(8'hA0, 1'b0);
        add_stim(8'h80, 1'b0);
        add_stim(8'hED, 1'b0);
        add_stim(8'hA0, 1'b0);
        add_stim(8'hF0, 1'b0);
        add_stim(8'h90, 1'b0);
        add_stim(8'h80, 1'b0);
        add_stim(8'h80, 1'b0);
        add_stim(8'hF4, 1'b0);
        add_stim(8'h90, 1'b0);
        add_stim(8'hE0, 1'b0);
        add_stim(8'h80, 1'b0);
        add_stim(8'hF4, 1'b0);
        add_stim(8'h8F, 1'b0);
        add_stim(8'hBF, 1'b1);
        add_stim(8'hF1, 1'b0);
        add_stim(8'h80, 1'b0);
        add_stim(8'h80, 1'b0);
        add_stim(8'hC0, 1'b1);

        while (stim_q.size() < 29 + RANDOM_BYTES) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                add_sequence(1'b0);
            end else if (pick < 8) begin
                add_stim(cont_in(8'h00, 8'hFF), $urandom_range(0, 19) == 0);
            end else begin
                add_sequence(1'b1);
            end
        end

        foreach (stim_q[i]) begin
            if (i == stim_q.size() / 2) begin
                hold_until_drained();
            end
            if (i >= stim_q.size() - CALM_TAIL) begin
                idle_on = 1'b0;
            end
            send_request(stim_q[i]);
        end
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.waiting() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
